/* sv/tkga_pkg.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator package
// Shared widths and the request record passed from the front to the back.
// ----------------------------------------------------------------------------
package tkga_pkg;

    // Sample and arithmetic widths
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;         // f component times kernel lane
    localparam int MIX_W    = PROD_W + 2;           // sum of three products
    localparam int DOT_W    = SAMPLE_W + MIX_W;     // g component times mixed lane
    localparam int TERM_W   = DOT_W + 3;            // sum of three, doubled
    localparam int ACC_W    = 64;
    localparam int LANES    = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Saturation limits of one accumulator lane
    localparam logic [ACC_W-1:0] LANE_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] LANE_MAX = {1'b0, {(ACC_W-1){1'b1}}};

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Classified request: forward vector, gradient vector, kernel, run end
    typedef struct packed {
        sample_t f_x;
        sample_t f_y;
        sample_t f_z;
        sample_t g_x;
        sample_t g_y;
        sample_t g_z;
        sample_t q_0;
        sample_t q_1;
        sample_t q_2;
        sample_t q_3;
        logic    last;
    } work_t;

endpackage

/* sv/tkga_if.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator channels
// Valid/ready channels for incoming requests and outgoing gradient sums.
// ----------------------------------------------------------------------------
interface tkga_item_if;
    import tkga_pkg::*;

    logic    valid;
    logic    ready;
    sample_t in_x;
    sample_t in_y;
    sample_t in_z;
    sample_t out_x;
    sample_t out_y;
    sample_t out_z;
    sample_t kern_x;
    sample_t kern_y;
    sample_t kern_z;
    sample_t kern_w;
    logic    last;

    modport source (
        output valid, in_x, in_y, in_z, out_x, out_y, out_z,
               kern_x, kern_y, kern_z, kern_w, last,
        input  ready
    );
    modport sink (
        input  valid, in_x, in_y, in_z, out_x, out_y, out_z,
               kern_x, kern_y, kern_z, kern_w, last,
        output ready
    );
endinterface

interface tkga_result_if;
    import tkga_pkg::*;

    logic valid;
    logic ready;
    acc_t grad_x;
    acc_t grad_y;
    acc_t grad_z;
    acc_t grad_w;

    modport source (
        output valid, grad_x, grad_y, grad_z, grad_w,
        input  ready
    );
    modport sink (
        input  valid, grad_x, grad_y, grad_z, grad_w,
        output ready
    );
endinterface

/* sv/tkga_front.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator front end
// Holds the role swap setting, accepts requests and sorts their vectors into
// forward and gradient roles before they enter the queue.
// ----------------------------------------------------------------------------
module tkga_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    tkga_item_if.sink            item,
    input  logic                 queue_full,
    output logic                 push,
    output tkga_pkg::work_t      push_data
);
    import tkga_pkg::*;

    logic swap_reg;
    logic swap_next;

    // Role swap register; the user must write it only while the block is idle, which the block itself does not enforce.
    always_comb
    begin
        swap_next = swap_reg;
        if (cfg_wr_en)
        begin
            swap_next = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
        end
        else
        begin
            swap_reg <= swap_next;
        end
    end

    // A request is taken whenever the queue has room.
    assign item.ready = !queue_full;
    assign push       = item.valid && !queue_full;

    // Pick forward and gradient vectors according to the role setting.
    always_comb
    begin
        if (swap_reg)
        begin
            push_data.f_x = item.out_x;
            push_data.f_y = item.out_y;
            push_data.f_z = item.out_z;
            push_data.g_x = item.in_x;
            push_data.g_y = item.in_y;
            push_data.g_z = item.in_z;
        end
        else
        begin
            push_data.f_x = item.in_x;
            push_data.f_y = item.in_y;
            push_data.f_z = item.in_z;
            push_data.g_x = item.out_x;
            push_data.g_y = item.out_y;
            push_data.g_z = item.out_z;
        end
        push_data.q_0  = item.kern_x;
        push_data.q_1  = item.kern_y;
        push_data.q_2  = item.kern_z;
        push_data.q_3  = item.kern_w;
        push_data.last = item.last;
    end

endmodule

/* sv/tkga_queue.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator request queue
// Small first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
module tkga_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tkga_pkg::work_t      push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output tkga_pkg::work_t      pop_data
);
    import tkga_pkg::*;

    work_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/tkga_back.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator back end
// Five-stage pipeline: kernel products, quaternion mixing, gradient products,
// doubled dot product, then saturating accumulation and the result register.
// ----------------------------------------------------------------------------
module tkga_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 work_valid,
    input  tkga_pkg::work_t      work_data,
    output logic                 work_pop,
    tkga_result_if.source        result
);
    import tkga_pkg::*;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [MIX_W-1:0]  mix_t;
    typedef logic signed [DOT_W-1:0]  dot_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ACC_W:0]    wide_t;

    // Stage control
    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic    s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic    stall;
    logic    advance;

    // Stage payload
    sample_t q      [LANES];
    prod_t   a_next [LANES];
    prod_t   b_next [LANES];
    prod_t   c_next [LANES];
    prod_t   a_reg  [LANES];
    prod_t   b_reg  [LANES];
    prod_t   c_reg  [LANES];
    sample_t g1_reg [3];
    sample_t g2_reg [3];
    mix_t    mx_next [LANES];
    mix_t    my_next [LANES];
    mix_t    mz_next [LANES];
    mix_t    mx_reg  [LANES];
    mix_t    my_reg  [LANES];
    mix_t    mz_reg  [LANES];
    dot_t    px_next [LANES];
    dot_t    py_next [LANES];
    dot_t    pz_next [LANES];
    dot_t    px_reg  [LANES];
    dot_t    py_reg  [LANES];
    dot_t    pz_reg  [LANES];
    term_t   term_next [LANES];
    term_t   term_reg  [LANES];

    // Accumulators and result register
    acc_t    acc_reg  [LANES];
    acc_t    acc_next [LANES];
    acc_t    sat_sum  [LANES];
    wide_t   wide_sum [LANES];
    acc_t    grad_reg  [LANES];
    acc_t    grad_next [LANES];
    logic    out_valid_reg;
    logic    out_valid_next;

    // The whole pipeline holds only when a run end meets a result still waiting.
    assign stall    = s4_valid_reg && s4_last_reg && out_valid_reg && !result.ready;
    assign advance  = !stall;
    assign work_pop = work_valid && advance;

    // Stage 1: forward components times each kernel lane.
    assign q[0] = work_data.q_0;
    assign q[1] = work_data.q_1;
    assign q[2] = work_data.q_2;
    assign q[3] = work_data.q_3;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            a_next[i] = PROD_W'($signed(work_data.f_x) * $signed(q[i]));
            b_next[i] = PROD_W'($signed(work_data.f_y) * $signed(q[i]));
            c_next[i] = PROD_W'($signed(work_data.f_z) * $signed(q[i]));
        end
    end

    // Stage 2: quaternion mixing into the X, Y and Z lane sets.
    always_comb
    begin
        mx_next[0] = MIX_W'(c_reg[2]) + MIX_W'(a_reg[0]) - MIX_W'(b_reg[3]);
        mx_next[1] = MIX_W'(c_reg[3]) + MIX_W'(a_reg[1]) + MIX_W'(b_reg[2]);
        mx_next[2] = MIX_W'(c_reg[0]) - MIX_W'(a_reg[2]) + MIX_W'(b_reg[1]);
        mx_next[3] = MIX_W'(c_reg[1]) - MIX_W'(a_reg[3]) - MIX_W'(b_reg[0]);

        my_next[0] = MIX_W'(a_reg[3]) + MIX_W'(b_reg[0]) - MIX_W'(c_reg[1]);
        my_next[1] = MIX_W'(a_reg[2]) - MIX_W'(b_reg[1]) - MIX_W'(c_reg[0]);
        my_next[2] = MIX_W'(a_reg[1]) + MIX_W'(b_reg[2]) + MIX_W'(c_reg[3]);
        my_next[3] = MIX_W'(a_reg[0]) - MIX_W'(b_reg[3]) + MIX_W'(c_reg[2]);

        mz_next[0] = MIX_W'(b_reg[1]) + MIX_W'(c_reg[0]) - MIX_W'(a_reg[2]);
        mz_next[1] = MIX_W'(b_reg[0]) - MIX_W'(c_reg[1]) + MIX_W'(a_reg[3]);
        mz_next[2] = MIX_W'(b_reg[3]) - MIX_W'(c_reg[2]) - MIX_W'(a_reg[0]);
        mz_next[3] = MIX_W'(b_reg[2]) + MIX_W'(c_reg[3]) + MIX_W'(a_reg[1]);
    end

    // Stage 3: gradient components times the mixed lanes.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            px_next[i] = DOT_W'($signed(g2_reg[0]) * $signed(mx_reg[i]));
            py_next[i] = DOT_W'($signed(g2_reg[1]) * $signed(my_reg[i]));
            pz_next[i] = DOT_W'($signed(g2_reg[2]) * $signed(mz_reg[i]));
        end
    end

    // Stage 4: sum of the three products, doubled.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            term_next[i] = (TERM_W'(px_reg[i]) + TERM_W'(py_reg[i]) + TERM_W'(pz_reg[i]))
                           <<< 1;
        end
    end

    // Stage 5: saturating accumulation; a run end loads the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            wide_sum[i]  = (ACC_W+1)'(acc_reg[i]) + (ACC_W+1)'(term_reg[i]);
            if (wide_sum[i][ACC_W] != wide_sum[i][ACC_W-1])
            begin
                sat_sum[i] = wide_sum[i][ACC_W] ? LANE_MIN : LANE_MAX;
            end
            else
            begin
                sat_sum[i] = wide_sum[i][ACC_W-1:0];
            end
            acc_next[i]  = acc_reg[i];
            grad_next[i] = grad_reg[i];
            if (s4_valid_reg && advance)
            begin
                acc_next[i] = sat_sum[i];
                if (s4_last_reg)
                begin
                    acc_next[i]  = '0;
                    grad_next[i] = sat_sum[i];
                end
            end
        end
        if (s4_valid_reg && s4_last_reg && advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers of the pipeline and the accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg <= work_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
            end
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < LANES; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Payload registers of the pipeline and the result.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= work_data.last;
            s2_last_reg <= s1_last_reg;
            s3_last_reg <= s2_last_reg;
            s4_last_reg <= s3_last_reg;
            g1_reg[0]   <= work_data.g_x;
            g1_reg[1]   <= work_data.g_y;
            g1_reg[2]   <= work_data.g_z;
            g2_reg      <= g1_reg;
            for (int i = 0; i < LANES; i++)
            begin
                a_reg[i]    <= a_next[i];
                b_reg[i]    <= b_next[i];
                c_reg[i]    <= c_next[i];
                mx_reg[i]   <= mx_next[i];
                my_reg[i]   <= my_next[i];
                mz_reg[i]   <= mz_next[i];
                px_reg[i]   <= px_next[i];
                py_reg[i]   <= py_next[i];
                pz_reg[i]   <= pz_next[i];
                term_reg[i] <= term_next[i];
            end
        end
        for (int i = 0; i < LANES; i++)
        begin
            grad_reg[i] <= grad_next[i];
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.grad_x = grad_reg[0];
    assign result.grad_y = grad_reg[1];
    assign result.grad_z = grad_reg[2];
    assign result.grad_w = grad_reg[3];

endmodule

/* sv/trivector_kernel_gradient_accumulator.sv */
// Path: a request with last set passes the queue, the stage 1 to stage 4
// registers and the accumulate stage, which loads the result register that
// drives the result channel.
// Throughput: one request per cycle; the result register only holds the
// pipeline when a new run end arrives while the previous sums are not taken.
// Reset: rst_n clears the queue, the pipeline, the accumulators and the role
// swap setting asynchronously.
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator
// Accumulates the quaternion kernel gradient of a trivector convolution into
// four saturating 64-bit lanes and emits them at the end of each run.
// ----------------------------------------------------------------------------
module trivector_kernel_gradient_accumulator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    tkga_item_if.sink     item,
    tkga_result_if.source result
);
    import tkga_pkg::*;

    logic  queue_full;
    logic  queue_push;
    work_t queue_in;
    logic  queue_pop;
    logic  queue_not_empty;
    work_t queue_out;

    // Request intake and role sorting.
    tkga_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .queue_full  (queue_full),
        .push        (queue_push),
        .push_data   (queue_in)
    );

    // Decoupling queue.
    tkga_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_data (queue_in),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_out)
    );

    // Arithmetic pipeline and accumulators.
    tkga_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_not_empty),
        .work_data  (queue_out),
        .work_pop   (queue_pop),
        .result     (result)
    );

endmodule

/* tb/sv/tb_trivector_kernel_gradient_accumulator.sv */
// ----------------------------------------------------------------------------
// Trivector kernel gradient accumulator testbench
// Drives requests with random fields and random idle and stall patterns.
// A predictor in the bench accumulates the expected gradient sums, and every
// emitted result is compared lane by lane with the oldest expected one.
// Directed tests cover field extremes, both role settings, a role change
// inside a run, runs without an end, and long runs of large sums of both signs.
// ----------------------------------------------------------------------------
module tb_trivector_kernel_gradient_accumulator;
    import tkga_pkg::*;

    localparam int      CLK_PERIOD    = 8;
    localparam int      RESET_CYCLES  = 7;
    localparam int      DRAIN_CYCLES  = 12;
    localparam int      LARGE_REPEATS = 12;
    localparam longint  WATCHDOG      = 64'd10_000_000;
    localparam sample_t S_MAX         = 16'sh7fff;
    localparam sample_t S_MIN         = 16'sh8000;
    localparam sample_t S_ONE         = 16'sh4000;

    // One request as it appears on the item channel.
    typedef struct packed {
        sample_t in_x;
        sample_t in_y;
        sample_t in_z;
        sample_t out_x;
        sample_t out_y;
        sample_t out_z;
        sample_t kern_x;
        sample_t kern_y;
        sample_t kern_z;
        sample_t kern_w;
        logic    last;
    } grad_req_t;

    // One set of emitted gradient sums.
    typedef struct packed {
        acc_t x;
        acc_t y;
        acc_t z;
        acc_t w;
    } grad_sums_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    tkga_item_if   item_ch ();
    tkga_result_if result_ch ();

    trivector_kernel_gradient_accumulator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    // Predictor state: running lane sums and the role setting.
    acc_t       grad_acc [4];
    logic       roles_swapped;
    grad_sums_t pending_sums [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int errors         = 0;
    int requests_sent  = 0;
    int sums_checked   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Count one mismatch and print its line for the first 40 mismatches.
    task automatic report_mismatch(input string what, input acc_t got, input acc_t want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    // Add one accepted request to the predicted lane sums; on a run end,
    // queue the sums and clear the lanes.
    function automatic void accumulate_request(input grad_req_t r);
        longint             fv [3];
        longint             gv [3];
        longint             kq [4];
        longint             pa [4];
        longint             pb [4];
        longint             pc [4];
        longint             mx [4];
        longint             my [4];
        longint             mz [4];
        longint             term;
        logic signed [64:0] wide;
        grad_sums_t         sums;
        int                 i;

        if (roles_swapped)
        begin
            fv[0] = r.out_x; fv[1] = r.out_y; fv[2] = r.out_z;
            gv[0] = r.in_x;  gv[1] = r.in_y;  gv[2] = r.in_z;
        end
        else
        begin
            fv[0] = r.in_x;  fv[1] = r.in_y;  fv[2] = r.in_z;
            gv[0] = r.out_x; gv[1] = r.out_y; gv[2] = r.out_z;
        end
        kq[0] = r.kern_x; kq[1] = r.kern_y; kq[2] = r.kern_z; kq[3] = r.kern_w;

        for (i = 0; i < 4; i++)
        begin
            pa[i] = fv[0] * kq[i];
            pb[i] = fv[1] * kq[i];
            pc[i] = fv[2] * kq[i];
        end

        mx[0] = pc[2] + pa[0] - pb[3];
        mx[1] = pc[3] + pa[1] + pb[2];
        mx[2] = pc[0] - pa[2] + pb[1];
        mx[3] = pc[1] - pa[3] - pb[0];

        my[0] = pa[3] + pb[0] - pc[1];
        my[1] = pa[2] - pb[1] - pc[0];
        my[2] = pa[1] + pb[2] + pc[3];
        my[3] = pa[0] - pb[3] + pc[2];

        mz[0] = pb[1] + pc[0] - pa[2];
        mz[1] = pb[0] - pc[1] + pa[3];
        mz[2] = pb[3] - pc[2] - pa[0];
        mz[3] = pb[2] + pc[3] + pa[1];

        // Each lane saturates at the signed 64-bit limits.
        for (i = 0; i < 4; i++)
        begin
            term = 2 * (gv[0] * mx[i] + gv[1] * my[i] + gv[2] * mz[i]);
            wide = grad_acc[i] + term;
            if (wide[64] != wide[63])
                grad_acc[i] = wide[64] ? LANE_MIN : LANE_MAX;
            else
                grad_acc[i] = wide[63:0];
        end

        if (r.last)
        begin
            sums = '{grad_acc[0], grad_acc[1], grad_acc[2], grad_acc[3]};
            pending_sums.push_back(sums);
            for (i = 0; i < 4; i++)
                grad_acc[i] = '0;
        end
    endfunction

    function automatic grad_req_t make_request(
        input sample_t ix, input sample_t iy, input sample_t iz,
        input sample_t ox, input sample_t oy, input sample_t oz,
        input sample_t kx, input sample_t ky, input sample_t kz, input sample_t kw,
        input logic    run_end
    );
        return '{ix, iy, iz, ox, oy, oz, kx, ky, kz, kw, run_end};
    endfunction

    // Random sample with extra weight on the extremes and on values near zero.
    function automatic sample_t random_sample();
        case ($urandom_range(5))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return sample_t'(int'($urandom_range(16)) - 8);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic grad_req_t random_request();
        return make_request(random_sample(), random_sample(), random_sample(),
                            random_sample(), random_sample(), random_sample(),
                            random_sample(), random_sample(), random_sample(),
                            random_sample(), $urandom_range(7) == 0);
    endfunction

    // Send one request, with an optional idle gap before it, and wait
    // until the block accepts it.
    task automatic send_request(input grad_req_t r);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        item_ch.in_x   <= r.in_x;
        item_ch.in_y   <= r.in_y;
        item_ch.in_z   <= r.in_z;
        item_ch.out_x  <= r.out_x;
        item_ch.out_y  <= r.out_y;
        item_ch.out_z  <= r.out_z;
        item_ch.kern_x <= r.kern_x;
        item_ch.kern_y <= r.kern_y;
        item_ch.kern_z <= r.kern_z;
        item_ch.kern_w <= r.kern_w;
        item_ch.last   <= r.last;
        item_ch.valid  <= 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        accumulate_request(r);
        requests_sent++;
    endtask

    // Stop sending, wait for every expected result, then let the pipeline
    // empty of requests that carry no run end.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the role setting while the block is idle.
    task automatic set_roles(input logic swap);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= swap;
        @(posedge clk);
        roles_swapped = swap;
        cfg_wr_en    <= 1'b0;
    endtask

    // Field extremes, unit vectors and both role settings.
    task automatic test_directed_extremes();
        send_request(make_request('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
        send_request(make_request(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                                  S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
        send_request(make_request(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                                  S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
        send_request(make_request(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                                  S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
        send_request(make_request(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                                  S_MAX, S_MIN, S_MAX, S_MIN, 1'b1));
        send_request(make_request(S_ONE, '0, '0, '0, S_ONE, '0,
                                  S_ONE, '0, '0, '0, 1'b0));
        send_request(make_request('0, '0, S_ONE, '0, '0, -S_ONE,
                                  '0, '0, '0, S_ONE, 1'b0));
        send_request(make_request('0, S_ONE, '0, S_ONE, '0, '0,
                                  '0, S_ONE, '0, '0, 1'b1));
        send_request(make_request(-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1,
                                  -16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b1));

        // Transpose mode: input and output vectors trade roles.
        set_roles(1'b1);
        send_request(make_request(S_ONE, '0, '0, '0, S_ONE, '0,
                                  S_ONE, '0, '0, '0, 1'b1));
        send_request(make_request(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN,
                                  S_MIN, S_MAX, S_MIN, S_MAX, 1'b1));
        send_request(make_request(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX,
                                  S_MIN, S_MIN, S_MIN, S_MIN, 1'b1));
        set_roles(1'b0);
    endtask

    // A run with no end emits nothing; a role change inside a run keeps the
    // lane sums and applies from the next request on.
    task automatic test_role_change_mid_run();
        grad_req_t r;

        set_roles(1'b1);
        repeat (4)
        begin
            r = random_request();
            r.last = 1'b0;
            send_request(r);
        end
        set_roles(1'b0);
        repeat (3)
        begin
            r = random_request();
            r.last = 1'b0;
            send_request(r);
        end
        set_roles(1'b1);
        r = random_request();
        r.last = 1'b1;
        send_request(r);
        set_roles(1'b0);
    endtask

    // Push lane sums to large magnitudes of both signs with runs of extreme
    // requests, then pull them back with requests of the opposite sign.
    task automatic test_large_sums();
        grad_req_t drive_req;
        grad_req_t push_req;
        sample_t   g_hi;
        sample_t   g_lo;

        set_roles(1'b0);
        for (int dir = 0; dir < 2; dir++)
        begin
            g_hi = (dir == 0) ? S_MIN : S_MAX;
            g_lo = (dir == 0) ? S_MAX : S_MIN;
            drive_req = make_request(S_MIN, S_MIN, S_MIN, g_hi, g_lo, g_hi,
                                     S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
            push_req  = make_request(S_MIN, S_MIN, S_MIN, g_lo, g_hi, g_lo,
                                     S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
            repeat (LARGE_REPEATS) send_request(drive_req);
            repeat (3) send_request(push_req);
            send_request(make_request('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1));
        end
    endtask

    // Random requests in four idle/stall phases, the role setting toggled
    // halfway through each phase without closing the open run.
    task automatic test_random_traffic();
        int        pct_src [4] = '{0, 59, 0, 26};
        int        pct_snk [4] = '{0, 0, 59, 26};
        grad_req_t r;

        for (int ph = 0; ph < 4; ph++)
        begin
            set_roles(ph % 2 == 1);
            src_idle_pct   = pct_src[ph];
            sink_stall_pct = pct_snk[ph];
            for (int half = 0; half < 2; half++)
            begin
                if (half == 1)
                    set_roles(!roles_swapped);
                repeat (205) send_request(random_request());
            end
            r = random_request();
            r.last = 1'b1;
            send_request(r);
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Result side: random stalls, and each accepted result is compared with
    // the oldest expected sums.
    always @(posedge clk)
    begin : result_check
        grad_sums_t want;

        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected result, grad_x", result_ch.grad_x, '0);
            end
            else
            begin
                want = pending_sums.pop_front();
                if (result_ch.grad_x !== want.x)
                    report_mismatch("grad_x", result_ch.grad_x, want.x);
                if (result_ch.grad_y !== want.y)
                    report_mismatch("grad_y", result_ch.grad_y, want.y);
                if (result_ch.grad_z !== want.z)
                    report_mismatch("grad_z", result_ch.grad_z, want.z);
                if (result_ch.grad_w !== want.w)
                    report_mismatch("grad_w", result_ch.grad_w, want.w);
                sums_checked++;
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(WATCHDOG);
        $display("Timeout with %0d results still expected", pending_sums.size());
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.in_x       = '0;
        item_ch.in_y       = '0;
        item_ch.in_z       = '0;
        item_ch.out_x      = '0;
        item_ch.out_y      = '0;
        item_ch.out_z      = '0;
        item_ch.kern_x     = '0;
        item_ch.kern_y     = '0;
        item_ch.kern_z     = '0;
        item_ch.kern_w     = '0;
        item_ch.last       = 1'b0;
        roles_swapped      = 1'b0;
        for (int i = 0; i < 4; i++)
            grad_acc[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_role_change_mid_run();
        test_large_sums();
        test_random_traffic();
        wait_drained();

        $display("Checked %0d gradient sums from %0d requests in both role settings,",
                 sums_checked, requests_sent);
        $display("with idle and stall phases and long runs of large sums of both signs.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* trivector_kernel_gradient_accumulator.f */
sv/tkga_pkg.sv
sv/tkga_if.sv
sv/tkga_front.sv
sv/tkga_queue.sv
sv/tkga_back.sv
sv/trivector_kernel_gradient_accumulator.sv
tb/sv/tb_trivector_kernel_gradient_accumulator.sv
